### rtl/fcrc_pkg.sv
// Shared types, constants and the byte-wide CRC-16 update for the frame checksum block.
package fcrc_pkg;

  typedef logic [15:0] crc_t;

  localparam crc_t        CRC_POLY        = 16'h1021;
  localparam crc_t        CRC_INIT        = 16'h0000;
  localparam crc_t        EMPTY_FRAME_CRC = 16'h0001;
  localparam logic [5:0]  CHAR_BASE       = 6'h30;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Checksum handed from the front end to the serializer.
  typedef struct packed {
    logic valid;
    crc_t crc;
  } crc_req_t;

  // Folds one byte MSB-first (XMODEM): eight shift steps on a 16-bit value.
  function automatic crc_t crc_fold(crc_t acc_in, logic [7:0] data);
    crc_t acc;
    logic [7:0] d;
    acc = acc_in;
    d   = data;
    for (int k = 0; k < 8; k++) begin
      if (d[7] ^ acc[15]) begin
        acc = {acc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        acc = {acc[14:0], 1'b0};
      end
      d = {d[6:0], 1'b0};
    end
    return acc;
  endfunction

endpackage

### rtl/fcrc_front.sv
// Front end: takes characters, skips the first of each frame, folds the rest into the CRC.
module fcrc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic              q_full,
  input  logic [7:0]        in_data_byte,
  input  logic              in_last_byte,
  input  logic              in_empty_frame,
  output fcrc_pkg::crc_req_t crc_req
);
  import fcrc_pkg::*;

  crc_t crc_r, crc_nxt;
  logic skip_r, skip_nxt;
  logic accept;
  crc_t folded;

  assign accept = in_push & ~q_full;
  assign folded = skip_r ? crc_r : crc_fold(crc_r, in_data_byte);

  always_comb begin
    crc_nxt       = crc_r;
    skip_nxt      = skip_r;
    crc_req.valid = 1'b0;
    crc_req.crc   = folded;
    if (accept) begin
      if (in_empty_frame) begin
        // empty frame: fixed checksum, anything gathered so far is dropped
        crc_req.valid = 1'b1;
        crc_req.crc   = EMPTY_FRAME_CRC;
        crc_nxt       = CRC_INIT;
        skip_nxt      = 1'b1;
      end else if (in_last_byte) begin
        crc_req.valid = 1'b1;
        crc_nxt       = CRC_INIT;
        skip_nxt      = 1'b1;
      end else begin
        crc_nxt  = folded;
        skip_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= CRC_INIT;
      skip_r <= 1'b1;
    end else begin
      crc_r  <= crc_nxt;
      skip_r <= skip_nxt;
    end
  end

endmodule

### rtl/fcrc_queue.sv
// Small register queue of finished checksums between front end and serializer.
module fcrc_queue #(
  parameter int unsigned DEPTH = fcrc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fcrc_pkg::crc_req_t push_req,
  input  logic               pop,
  output logic               full,
  output logic               empty,
  output fcrc_pkg::crc_t     head
);
  import fcrc_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  crc_t             entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign head    = entries_r[rd_ptr_r];
  assign do_push = push_req.valid & ~full;
  assign do_pop  = pop & ~empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_req.crc;
    end
  end

endmodule

### rtl/fcrc_back.sv
// Serializer: turns each queued checksum into four ASCII-style nibble characters.
module fcrc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  fcrc_pkg::crc_t q_head,
  output logic           q_pop,
  input  logic           out_pop,
  output logic           out_empty,
  output logic [5:0]     out_char_code,
  output logic           out_last_char
);
  import fcrc_pkg::*;

  crc_t       cur_r, cur_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       busy_r, busy_nxt;
  logic       taken;
  logic [3:0] nib;

  assign taken     = busy_r & out_pop;
  assign out_empty = ~busy_r;

  always_comb begin
    case (idx_r)
      2'd0:    nib = cur_r[15:12];
      2'd1:    nib = cur_r[11:8];
      2'd2:    nib = cur_r[7:4];
      default: nib = cur_r[3:0];
    endcase
  end

  assign out_char_code = CHAR_BASE | {2'b00, nib};
  assign out_last_char = (idx_r == 2'd3);

  always_comb begin
    cur_nxt  = cur_r;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    q_pop    = 1'b0;
    if (!busy_r || (taken && out_last_char)) begin
      // free, or last character leaving: pick up the next checksum directly
      busy_nxt = ~q_empty;
      q_pop    = ~q_empty;
      cur_nxt  = q_head;
      idx_nxt  = 2'd0;
    end else if (taken) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

endmodule

### rtl/frame_crc16_ascii_nibbles.sv
// Top level of the frame checksum block: front end, checksum queue and serializer.
//
// Takes telegram characters one per cycle (push/full) and returns, for each frame, a
// CRC-16/XMODEM (poly 0x1021, init 0) over all characters but the first, as four
// characters high nibble first, each nibble ORed with 0x30 (so 10..15 show as ':'..'?').
// A request flagged empty_frame ends the frame at once and yields "0001". The front end
// folds a whole byte per cycle, so a character is taken every clock while the checksum
// queue has room; the serializer then takes four pops per frame, one character per cycle
// while out_pop is high, moving straight on to the next queued checksum. full rises only
// when QUEUE_DEPTH frame checksums wait behind the serializer, i.e. when frames arrive
// faster than their results are popped, as frames under four characters can. A frame's
// checksum passes through the queue register, then the serializer's cur_r register.
module frame_crc16_ascii_nibbles #(
  parameter int unsigned QUEUE_DEPTH = fcrc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic       in_empty_frame,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [5:0] out_char_code,
  output logic       out_last_char
);
  import fcrc_pkg::*;

  crc_req_t crc_req;
  logic     q_full, q_empty, q_pop;
  crc_t     q_head;

  assign in_full = q_full;

  // byte fold and frame bookkeeping
  fcrc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .q_full        (q_full),
    .in_data_byte  (in_data_byte),
    .in_last_byte  (in_last_byte),
    .in_empty_frame(in_empty_frame),
    .crc_req       (crc_req)
  );

  // finished checksums waiting to be serialized
  fcrc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_req(crc_req),
    .pop     (q_pop),
    .full    (q_full),
    .empty   (q_empty),
    .head    (q_head)
  );

  // four characters per checksum, held in registers until popped
  fcrc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_pop      (out_pop),
    .out_empty    (out_empty),
    .out_char_code(out_char_code),
    .out_last_char(out_last_char)
  );

endmodule

### tb/sv/tb.sv
// Self-checking testbench for frame_crc16_ascii_nibbles: frame CRC-16 to four checksum chars.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fcrc_pkg::*;

  // One checksum character as it leaves the block.
  typedef struct packed {
    logic [5:0] code;
    logic       fin;
  } ascii_char_t;

  logic       clk;
  logic       rst_n;
  logic       in_push;
  logic       in_full;
  logic [7:0] in_data_byte;
  logic       in_last_byte;
  logic       in_empty_frame;
  logic       out_empty;
  logic       out_pop;
  logic [5:0] out_char_code;
  logic       out_last_char;

  frame_crc16_ascii_nibbles dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_data_byte  (in_data_byte),
    .in_last_byte  (in_last_byte),
    .in_empty_frame(in_empty_frame),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

  // Free-running clock, 8 ns period.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Predictor state: running checksum and the "drop the first byte" flag.
  crc_t        frame_crc;
  bit          drop_first;
  ascii_char_t pending_chars[$];

  // Idle controls for each side, and the long receiver hold-off request.
  bit sender_idle;
  bit receiver_idle;
  int pop_holdoff;

  // Bookkeeping.
  int failures;
  int requests_sent;
  int frames_closed;
  int chars_checked;
  int full_stalls;

  // Bitwise MSB-first CRC-16 step over one byte, poly 0x1021.
  function automatic crc_t crc_add_byte(crc_t acc, logic [7:0] b);
    crc_t r;
    logic fb;
    r = acc;
    for (int k = 7; k >= 0; k--) begin
      fb = r[15] ^ b[k];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  // Applies one accepted request to the predictor; queues the four chars at frame end.
  task automatic predict_request(input logic [7:0] b, input logic lastb, input logic emptyf);
    crc_t        sum;
    ascii_char_t c;
    if (emptyf) begin
      // Empty frame: fixed checksum, whatever was folded so far is thrown away.
      sum = EMPTY_FRAME_CRC;
    end else begin
      if (drop_first) begin
        drop_first = 1'b0;
      end else begin
        frame_crc = crc_add_byte(frame_crc, b);
      end
      if (!lastb) begin
        return;
      end
      sum = frame_crc;
    end
    for (int k = 3; k >= 0; k--) begin
      c.code = CHAR_BASE | {2'b00, sum[4*k +: 4]};
      c.fin  = (k == 0);
      pending_chars.push_back(c);
    end
    frame_crc  = CRC_INIT;
    drop_first = 1'b1;
    frames_closed++;
  endtask

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // Sends one request. Entered and left at a falling edge; push stays high when
  // the next request follows without a gap.
  task automatic send_request(input logic [7:0] b, input logic lastb, input logic emptyf);
    int gap;
    gap = sender_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push        <= 1'b1;
    in_data_byte   <= b;
    in_last_byte   <= lastb;
    in_empty_frame <= emptyf;
    do begin
      @(posedge clk);
    end while (in_full);
    predict_request(b, lastb, emptyf);
    requests_sent++;
    @(negedge clk);
  endtask

  // Random byte with extra weight on the all-zero and all-one patterns.
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return 8'h00;
    end else if (r == 1) begin
      return 8'hFF;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Receiver: a random number of idle cycles per character while receiver_idle is set, or a long hold-off on
  // request. While waiting with pop high it still notices a new hold-off request.
  initial begin
    int w;
    out_pop = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (pop_holdoff > 0) begin
        w           = pop_holdoff;
        pop_holdoff = 0;
      end else begin
        w = receiver_idle ? $urandom_range(0, 15) : 0;
      end
      if (w > 0) begin
        out_pop <= 1'b0;
        repeat (w) @(negedge clk);
      end
      out_pop <= 1'b1;
      do begin
        @(posedge clk);
      end while (out_empty && pop_holdoff == 0);
      @(negedge clk);
    end
  end

  // Result checker: every popped char against the oldest predicted one.
  always @(posedge clk) begin : check_chars
    ascii_char_t want;
    if (rst_n) begin
      if (in_push && in_full) begin
        full_stalls++;
      end
      if (out_pop && !out_empty) begin
        if (pending_chars.size() == 0) begin
          note_failure($sformatf("unexpected char code=%h last=%b",
                                 out_char_code, out_last_char));
        end else begin
          want = pending_chars.pop_front();
          chars_checked++;
          if (out_char_code !== want.code) begin
            note_failure($sformatf("char_code exp=%h got=%h", want.code, out_char_code));
          end
          if (out_last_char !== want.fin) begin
            note_failure($sformatf("last_char exp=%b got=%b", want.fin, out_last_char));
          end
        end
      end
    end
  end

  // Directed frames: skipped first byte, one-byte frames, all-zero and all-one bytes,
  // nibbles above nine, empty frames with and without last_byte, an aborted frame.
  task automatic test_directed();
    logic [7:0] check_str[9];
    check_str = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
    // "123456789" behind a skipped lead byte: expect 0x31C3 -> "31<3".
    send_request(8'h3A, 1'b0, 1'b0);
    foreach (check_str[i]) begin
      send_request(check_str[i], (i == 8), 1'b0);
    end
    // One-byte frames give a zero checksum.
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hFF, 1'b1, 1'b0);
    // Zero bytes are folded like any other byte.
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'hFF, 1'b0, 1'b0);
    send_request(8'h00, 1'b1, 1'b0);
    // Empty frame; the data byte must be ignored.
    send_request(8'hA5, 1'b1, 1'b1);
    // Partly gathered frame cut short by an empty flag without last_byte.
    send_request(8'h55, 1'b0, 1'b0);
    send_request(8'hAA, 1'b0, 1'b0);
    send_request(8'hFF, 1'b0, 1'b1);
    // High bytes behind a skipped lead byte: expect 0x9277 -> "9277".
    send_request(8'hFF, 1'b0, 1'b0);
    send_request(8'hFF, 1'b0, 1'b0);
    send_request(8'h80, 1'b1, 1'b0);
  endtask

  // Random traffic, mostly well-formed frames with random content, some empty frames
  // and some frames cut short by an empty flag.
  task automatic test_random_frames(input int n_requests);
    int start_cnt;
    int frame_no;
    int kind;
    int len;
    start_cnt = requests_sent;
    frame_no  = 0;
    while (requests_sent - start_cnt < n_requests) begin
      // Idle pattern is picked anew every twelve frames, including stretches with none.
      if (frame_no % 12 == 0) begin
        case ($urandom_range(0, 3))
          0: begin sender_idle = 1; receiver_idle = 1; end
          1: begin sender_idle = 1; receiver_idle = 0; end
          2: begin sender_idle = 0; receiver_idle = 1; end
          default: begin sender_idle = 0; receiver_idle = 0; end
        endcase
      end
      frame_no++;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        send_request(pick_byte(), 1'($urandom_range(0, 1)), 1'b1);
      end else begin
        len = (kind < 85) ? $urandom_range(1, 8) : $urandom_range(9, 32);
        if (kind < 15) begin
          // Aborted frame: some bytes, then an empty flag.
          for (int i = 0; i < len; i++) begin
            send_request(pick_byte(), 1'b0, 1'b0);
          end
          send_request(pick_byte(), 1'($urandom_range(0, 1)), 1'b1);
        end else begin
          for (int i = 0; i < len; i++) begin
            send_request(pick_byte(), (i == len - 1), 1'b0);
          end
        end
      end
    end
  endtask

  // Receiver stops for a long while; short frames pile up until full stalls input.
  task automatic test_backpressure();
    sender_idle   = 0;
    receiver_idle = 0;
    pop_holdoff   = 300;
    for (int i = 0; i < 24; i++) begin
      if (i % 3 == 2) begin
        send_request(pick_byte(), 1'b1, 1'b1);
      end else begin
        send_request(pick_byte(), 1'b1, 1'b0);
      end
    end
    receiver_idle = 1;
    sender_idle   = 1;
  endtask

  // Stimulus sequence.
  initial begin
    int guard;
    rst_n          = 1'b0;
    in_push        = 1'b0;
    in_data_byte   = 8'h00;
    in_last_byte   = 1'b0;
    in_empty_frame = 1'b0;
    sender_idle    = 1;
    receiver_idle  = 1;
    pop_holdoff    = 0;
    failures       = 0;
    requests_sent  = 0;
    frames_closed  = 0;
    chars_checked  = 0;
    full_stalls    = 0;
    frame_crc      = CRC_INIT;
    drop_first     = 1'b1;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_backpressure();
    test_random_frames(224);
    in_push <= 1'b0;

    // Drain, then keep watching to catch stray results.
    guard = 0;
    while (pending_chars.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (16) @(posedge clk);
    if (pending_chars.size() != 0) begin
      note_failure($sformatf("%0d checksum chars never arrived", pending_chars.size()));
    end

    $display("Run covered %0d requests in %0d frames, %0d checksum chars compared,",
             requests_sent, frames_closed, chars_checked);
    $display("input stalled by full on %0d cycles; %0d failures.", full_stalls, failures);
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### frame_crc16_ascii_nibbles.f
rtl/fcrc_pkg.sv
rtl/fcrc_front.sv
rtl/fcrc_queue.sv
rtl/fcrc_back.sv
rtl/frame_crc16_ascii_nibbles.sv
tb/sv/tb.sv
